### src/wspr_symbol_sync_demapper_macros.svh
// Assertion macros for the WSPR symbol sync demapper.
// Included by the modules that check their own logic; no other dependencies.
`ifndef WSPR_SYMBOL_SYNC_DEMAPPER_MACROS_SVH
`define WSPR_SYMBOL_SYNC_DEMAPPER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define WSSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define WSSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WSSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define WSSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### src/wssd_pkg.sv
// Shared types, codes and the sync pattern for the WSPR symbol sync demapper.
// No dependencies; the interfaces and modules import it.
`default_nettype none

package wssd_pkg;

  localparam int SYMBOL_COUNT = 162;
  localparam int SYNC_IDX_W   = $clog2(SYMBOL_COUNT);
  localparam int BIT_INDEX_W  = 8;
  localparam int STATUS_W     = 3;

  // character codes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_THREE = 8'h33;

  // sync bit per symbol position, position 0 leftmost
  localparam logic [0:SYMBOL_COUNT-1] SYNC_PATTERN = {
    21'b110000001000111000100,
    21'b101111000000010010100,
    21'b000010110011010001101,
    21'b000011010101010010010,
    21'b110001101010001000001,
    21'b001001110110011010001,
    21'b110000010100110000000,
    15'b110101100011000
  };

  typedef enum logic [1:0] {
    PARSE_NONE     = 2'd0,
    PARSE_BAD_CHAR = 2'd1,
    PARSE_TOO_MANY = 2'd2
  } wssd_parse_e;

  typedef enum logic [1:0] {
    SYNC_NONE  = 2'd0,
    SYNC_BELOW = 2'd1,
    SYNC_ODD   = 2'd2
  } wssd_sync_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_CHAR    = 3'd1,
    ST_TOO_MANY    = 3'd2,
    ST_WRONG_COUNT = 3'd3,
    ST_BELOW_SYNC  = 3'd4,
    ST_ODD_DELTA   = 3'd5
  } wssd_status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       char_present;
    logic       last;
  } wssd_in_t;

  typedef struct packed {
    logic                   bit_valid;
    logic                   bit_value;
    logic [BIT_INDEX_W-1:0] bit_index;
    logic                   done_res;
    logic [STATUS_W-1:0]    status;
    logic [BIT_INDEX_W-1:0] error_index;
  } wssd_out_t;

  // character class handed from the classifier to the tracker
  typedef struct packed {
    logic       skip;
    logic       digit;
    logic [1:0] sym;
  } wssd_char_t;

endpackage

`default_nettype wire

### src/wssd_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on wssd_pkg for the payload types.
`default_nettype none

interface wssd_in_if import wssd_pkg::*; ();
  logic     valid;
  logic     ready;
  wssd_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wssd_out_if import wssd_pkg::*; ();
  logic      valid;
  logic      ready;
  wssd_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/wssd_char_class.sv
// Character classifier: separators, symbol digits and everything else.
// Depends on wssd_pkg for the character codes and the class struct.
`default_nettype none

module wssd_char_class import wssd_pkg::*; (
  input  logic [7:0] char_code_i,
  output wssd_char_t class_o
);

  logic [7:0] delta;

  assign delta = char_code_i - CHAR_ZERO;

  always_comb begin
    class_o.skip  = (char_code_i == CHAR_SPACE) || (char_code_i == CHAR_COMMA) ||
                    ((char_code_i >= CHAR_TAB) && (char_code_i <= CHAR_CR));
    class_o.digit = (char_code_i >= CHAR_ZERO) && (char_code_i <= CHAR_THREE);
    class_o.sym   = delta[1:0];
  end

endmodule

`default_nettype wire

### src/wssd_tracker.sv
// Frame tracker: symbol count, fault capture, sync removal and frame status.
// Depends on wssd_pkg and the assertion macro header.
`default_nettype none
`include "wspr_symbol_sync_demapper_macros.svh"

module wssd_tracker import wssd_pkg::*; #(
  parameter int SymbolCount = SYMBOL_COUNT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  wssd_in_t   item_i,
  input  wssd_char_t class_i,
  output wssd_out_t  res_o
);

  localparam int CntW = $clog2(SymbolCount + 1);

  logic [CntW-1:0]        count_q, count_d;
  wssd_parse_e            parse_q, parse_d;
  wssd_sync_e             sync_q, sync_d;
  logic [CntW-1:0]        sync_idx_q, sync_idx_d;

  logic                   active;
  logic                   in_range;
  logic                   sync_bit;
  logic [CntW-1:0]        count_n;
  wssd_parse_e            parse_n;
  wssd_sync_e             sync_n;
  logic [CntW-1:0]        sync_idx_n;

  assign active   = item_i.char_present && (parse_q == PARSE_NONE) && !class_i.skip;
  assign in_range = count_q < CntW'(SymbolCount);
  assign sync_bit = in_range ? SYNC_PATTERN[count_q[SYNC_IDX_W-1:0]] : 1'b0;

  always_comb begin
    count_n    = count_q;
    parse_n    = parse_q;
    sync_n     = sync_q;
    sync_idx_n = sync_idx_q;
    res_o      = '0;

    if (active) begin
      if (!class_i.digit) begin
        parse_n = PARSE_BAD_CHAR;
      end else if (!in_range) begin
        parse_n = PARSE_TOO_MANY;
      end else begin
        if (sync_bit && (class_i.sym == 2'd0)) begin
          if (sync_q == SYNC_NONE) begin
            sync_n     = SYNC_BELOW;
            sync_idx_n = count_q;
          end
        end else if (class_i.sym[0] ^ sync_bit) begin
          if (sync_q == SYNC_NONE) begin
            sync_n     = SYNC_ODD;
            sync_idx_n = count_q;
          end
        end else begin
          // even delta of 0 or 2: the data bit is its upper bit
          res_o.bit_valid = 1'b1;
          res_o.bit_value = class_i.sym[1];
          res_o.bit_index = BIT_INDEX_W'(count_q);
        end
        count_n = count_q + CntW'(1);
      end
    end

    if (item_i.last) begin
      res_o.done_res = 1'b1;
      case (parse_n)
        PARSE_BAD_CHAR: res_o.status = ST_BAD_CHAR;
        PARSE_TOO_MANY: res_o.status = ST_TOO_MANY;
        PARSE_NONE: begin
          if (count_n != CntW'(SymbolCount)) begin
            res_o.status = ST_WRONG_COUNT;
          end else begin
            case (sync_n)
              SYNC_BELOW: begin
                res_o.status      = ST_BELOW_SYNC;
                res_o.error_index = BIT_INDEX_W'(sync_idx_n);
              end
              SYNC_ODD: begin
                res_o.status      = ST_ODD_DELTA;
                res_o.error_index = BIT_INDEX_W'(sync_idx_n);
              end
              default: res_o.status = ST_OK;
            endcase
          end
        end
        default: res_o.status = ST_BAD_CHAR;
      endcase
    end
  end

  // clear the frame state after the status goes out
  always_comb begin
    count_d    = count_q;
    parse_d    = parse_q;
    sync_d     = sync_q;
    sync_idx_d = sync_idx_q;
    if (step_i) begin
      if (item_i.last) begin
        count_d    = '0;
        parse_d    = PARSE_NONE;
        sync_d     = SYNC_NONE;
        sync_idx_d = '0;
      end else begin
        count_d    = count_n;
        parse_d    = parse_n;
        sync_d     = sync_n;
        sync_idx_d = sync_idx_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      parse_q    <= PARSE_NONE;
      sync_q     <= SYNC_NONE;
      sync_idx_q <= '0;
    end else begin
      count_q    <= count_d;
      parse_q    <= parse_d;
      sync_q     <= sync_d;
      sync_idx_q <= sync_idx_d;
    end
  end

  `WSSD_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, step_i && item_i.last,
    (count_q == '0) && (parse_q == PARSE_NONE) && (sync_q == SYNC_NONE),
    "frame state not cleared after last word")
  `WSSD_ASSERT_NEXT(a_fault_freezes, clk_i, rst_ni,
    step_i && !item_i.last && (parse_q != PARSE_NONE), $stable(count_q),
    "symbol count moved after a parse fault")
  `WSSD_ASSERT_IMPL(a_sync_idx_counted, clk_i, rst_ni, sync_q != SYNC_NONE,
    sync_idx_q < count_q, "sync fault index not below symbol count")
  `WSSD_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1,
    count_q <= CntW'(SymbolCount), "symbol count beyond frame length")

endmodule

`default_nettype wire

### src/wspr_symbol_sync_demapper.sv
// WSPR symbol sync demapper, top level: input register, classifier,
// frame tracker and result register. Depends on wssd_pkg, wssd_if and the submodules.
//
// Usage: feed the text of one 162-symbol frame on in_i, one character per word,
// and mark the final word with last (char_present 0 gives a bare end marker).
// Separators and commas are skipped, digits 0 to 3 are channel symbols with
// the sync bit removed. Every input word gives exactly one result word on out_o:
// a data bit with its index when the symbol passed the sync check, and on the
// last word done_res with the frame status and the first sync error index.
// Timing: a word accepted on in_i lands in the input register, and its result
// is loaded into the output register when the word moves on, where it is
// offered until taken. Throughput: one word per cycle while the receiver
// keeps out_o.ready high, with the tracker's state update between the
// two registers.
// Reset clears the frame state and empties both registers.
// When the receiver stalls the result word holds, the input register keeps one
// more word, and then in_i.ready drops until out_o.ready returns.
`default_nettype none

module wspr_symbol_sync_demapper import wssd_pkg::*; #(
  parameter int SymbolCount = SYMBOL_COUNT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wssd_in_if.sink           in_i,
  wssd_out_if.source        out_o
);

  logic       in_valid_q;
  wssd_in_t   in_data_q;
  logic       out_valid_q;
  wssd_out_t  out_data_q;
  logic       advance;
  wssd_char_t char_class;
  wssd_out_t  result;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  wssd_char_class u_class (
    .char_code_i (in_data_q.char_code),
    .class_o     (char_class)
  );

  wssd_tracker #(
    .SymbolCount (SymbolCount)
  ) u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (in_data_q),
    .class_i (char_class),
    .res_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_data_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // load a result only when the word moves out of the input register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

endmodule

`default_nettype wire
